[hdl/assert_macros.svh]
// Assertion macros shared by the receive qualifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication or condition, checked outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/sriq_pkg.sv]
// Types, codes and constants of the serial receive input qualifier.
package sriq_pkg;

  localparam int LINES_PER_UNIT = 8;
  localparam int MAX_RES        = 5;
  localparam int Q_DEPTH        = 4;

  localparam logic [2:0] EV_DATA       = 3'd0;
  localparam logic [2:0] EV_CARRIER_UP = 3'd1;
  localparam logic [2:0] EV_HANGUP     = 3'd2;
  localparam logic [2:0] EV_INTERRUPT  = 3'd3;
  localparam logic [2:0] EV_RESUME     = 3'd4;
  localparam logic [2:0] EV_SUSPEND    = 3'd5;

  localparam int M_IXON   = 0;
  localparam int M_IXANY  = 1;
  localparam int M_INPCK  = 2;
  localparam int M_IGNBRK = 3;
  localparam int M_BRKINT = 4;
  localparam int M_IGNPAR = 5;
  localparam int M_PARMRK = 6;
  localparam int M_ISTRIP = 7;

  localparam logic [2:0] CFG_LINE_MODES  = 3'd0;
  localparam logic [2:0] CFG_CLOCAL_MASK = 3'd1;
  localparam logic [2:0] CFG_OPEN_MASK   = 3'd2;
  localparam logic [2:0] CFG_UNIT_INDEX  = 3'd3;
  localparam logic [2:0] CFG_TOTAL_LINES = 3'd4;
  localparam logic [2:0] CFG_START_CHAR  = 3'd5;
  localparam logic [2:0] CFG_STOP_CHAR   = 3'd6;

  localparam logic [6:0] TOTAL_LINES_RST = 7'd8;
  localparam logic [6:0] START_CHAR_RST  = 7'd17;
  localparam logic [6:0] STOP_CHAR_RST   = 7'd19;

  typedef struct packed {
    logic [63:0] line_modes;
    logic [7:0]  clocal_mask;
    logic [7:0]  open_mask;
    logic [2:0]  unit_index;
    logic [6:0]  total_lines;
    logic [6:0]  start_char;
    logic [6:0]  stop_char;
  } cfg_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] data;
  } ent_t;

  typedef struct packed {
    logic [2:0]               line;
    logic [2:0]               cnt;
    ent_t [MAX_RES-1:0]       ents;
  } plan_t;

endpackage

[hdl/sriq_front.sv]
// Front end: qualifies a received character, updates line state, builds its result list.
`include "assert_macros.svh"
module sriq_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sriq_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_line,
  input  logic [7:0]          in_char_code,
  input  logic                in_parity_error,
  input  logic                in_framing_error,
  input  logic                in_overrun_error,
  input  logic                in_carrier_detect,
  input  logic                q_full,
  output logic                push,
  output sriq_pkg::plan_t     push_plan
);

  logic [7:0] carrier_on_r, carrier_on_nxt;
  logic [7:0] out_stopped_r, out_stopped_nxt;
  logic       acc;
  logic       present;

  always_comb begin
    logic [7:0] m;
    logic [6:0] low7;
    logic       go;
    logic       err;
    logic [2:0] n;
    sriq_pkg::ent_t [sriq_pkg::MAX_RES-1:0] ents;
    m = cfg.line_modes[{in_line, 3'b000} +: 8];
    low7 = in_char_code[6:0];
    go = 1'b1;
    n = 3'd0;
    ents = '0;
    carrier_on_nxt = carrier_on_r;
    out_stopped_nxt = out_stopped_r;
    present = ({1'b0, in_line} < 4'(sriq_pkg::LINES_PER_UNIT)) &&
              ({1'b0, cfg.unit_index, in_line} < cfg.total_lines) &&
              cfg.open_mask[in_line];
    err = in_framing_error || in_overrun_error || (in_parity_error && m[sriq_pkg::M_INPCK]);
    if (!present) begin
      go = 1'b0;
    end else if (cfg.clocal_mask[in_line] || in_carrier_detect) begin
      if (!carrier_on_r[in_line]) begin
        carrier_on_nxt[in_line] = 1'b1;
        ents[n] = '{ev: sriq_pkg::EV_CARRIER_UP, data: 8'h00};
        n = n + 3'd1;
      end
    end else begin
      if (carrier_on_r[in_line]) begin
        carrier_on_nxt[in_line] = 1'b0;
        out_stopped_nxt[in_line] = 1'b0;
        ents[n] = '{ev: sriq_pkg::EV_HANGUP, data: 8'h00};
        n = n + 3'd1;
      end
      go = 1'b0;
    end
    if (go && m[sriq_pkg::M_IXON]) begin
      if (out_stopped_r[in_line]) begin
        if (low7 == cfg.start_char || m[sriq_pkg::M_IXANY]) begin
          out_stopped_nxt[in_line] = 1'b0;
          ents[n] = '{ev: sriq_pkg::EV_RESUME, data: 8'h00};
          n = n + 3'd1;
        end
      end else if (low7 == cfg.stop_char) begin
        out_stopped_nxt[in_line] = 1'b1;
        ents[n] = '{ev: sriq_pkg::EV_SUSPEND, data: 8'h00};
        n = n + 3'd1;
      end
      if (low7 == cfg.start_char || low7 == cfg.stop_char) begin
        go = 1'b0;
      end
    end
    if (go) begin
      if (err) begin
        if (in_char_code == 8'h00 && m[sriq_pkg::M_IGNBRK]) begin
          go = 1'b0;
        end else if (in_char_code == 8'h00 && m[sriq_pkg::M_BRKINT]) begin
          out_stopped_nxt[in_line] = 1'b0;
          ents[n] = '{ev: sriq_pkg::EV_INTERRUPT, data: 8'h00};
          n = n + 3'd1;
        end else if (in_char_code != 8'h00 && m[sriq_pkg::M_IGNPAR]) begin
          go = 1'b0;
        end else if (m[sriq_pkg::M_PARMRK]) begin
          ents[n] = '{ev: sriq_pkg::EV_DATA, data: 8'hff};
          n = n + 3'd1;
          ents[n] = '{ev: sriq_pkg::EV_DATA, data: 8'h00};
          n = n + 3'd1;
          ents[n] = '{ev: sriq_pkg::EV_DATA, data: in_char_code};
          n = n + 3'd1;
        end else begin
          ents[n] = '{ev: sriq_pkg::EV_DATA, data: 8'h00};
          n = n + 3'd1;
        end
      end else if (m[sriq_pkg::M_ISTRIP]) begin
        ents[n] = '{ev: sriq_pkg::EV_DATA, data: {1'b0, low7}};
        n = n + 3'd1;
      end else begin
        if (in_char_code == 8'hff && m[sriq_pkg::M_PARMRK]) begin
          ents[n] = '{ev: sriq_pkg::EV_DATA, data: 8'hff};
          n = n + 3'd1;
        end
        ents[n] = '{ev: sriq_pkg::EV_DATA, data: in_char_code};
        n = n + 3'd1;
      end
    end
    push_plan.line = in_line;
    push_plan.cnt = n;
    push_plan.ents = ents;
  end

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;
  assign push = acc && (push_plan.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_on_r <= '0;
      out_stopped_r <= '0;
    end else if (acc) begin
      carrier_on_r <= carrier_on_nxt;
      out_stopped_r <= out_stopped_nxt;
    end
  end

  `ASSERT_CLK(a_absent_keeps_state, clk, rst_n, acc && !present |=> carrier_on_r == $past(carrier_on_r) && out_stopped_r == $past(out_stopped_r), "Dropped character changed line state.")

endmodule

[hdl/sriq_queue.sv]
// Short queue of result lists between the front and back ends.
`include "assert_macros.svh"
module sriq_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sriq_pkg::plan_t push_plan,
  input  logic            pop,
  output logic            q_valid,
  output sriq_pkg::plan_t q_plan,
  output logic            q_full
);

  localparam int PTR_W = $clog2(sriq_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(sriq_pkg::Q_DEPTH + 1);

  sriq_pkg::plan_t    mem_r [sriq_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == CNT_W'(sriq_pkg::Q_DEPTH));
  assign q_plan  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && q_full, "Queue written while full.")
  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(sriq_pkg::Q_DEPTH), "Queue count out of range.")

endmodule

[hdl/sriq_back.sv]
// Back end: walks result lists, one result a cycle via an output register when not stalled.
`include "assert_macros.svh"
module sriq_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  sriq_pkg::plan_t q_plan,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_line,
  output logic [2:0]      out_event_res,
  output logic [7:0]      out_data_byte,
  output logic            out_last
);

  sriq_pkg::plan_t cur_r;
  logic            cur_valid_r;
  logic [2:0]      idx_r;
  logic            out_valid_r;
  logic [2:0]      out_line_r;
  logic [2:0]      out_ev_r;
  logic [7:0]      out_data_r;
  logic            out_last_r;
  logic            slot_free;
  logic            emit;
  logic            is_last;
  sriq_pkg::ent_t  ent;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = cur_valid_r && slot_free;
  assign is_last   = (idx_r == cur_r.cnt - 3'd1);
  assign pop       = q_valid && (!cur_valid_r || (emit && is_last));
  assign ent       = cur_r.ents[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        cur_valid_r <= 1'b1;
        idx_r <= '0;
      end else if (emit) begin
        if (is_last) begin
          cur_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_plan;
    end
    if (emit) begin
      out_line_r <= cur_r.line;
      out_ev_r <= ent.ev;
      out_data_r <= ent.data;
      out_last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line      = out_line_r;
  assign out_event_res = out_ev_r;
  assign out_data_byte = out_data_r;
  assign out_last      = out_last_r;

  `ASSERT_CLK(a_idx_in_list, clk, rst_n, cur_valid_r |-> idx_r < cur_r.cnt, "Result index past end of list.")

endmodule

[hdl/serial_receive_input_qualifier_unit.sv]
// Top level of the serial receive input qualifier: configuration registers and the three stages.
//
//  Channel   Ports                        Moves
//  in        in_valid / in_ready          one received character request
//  out       out_valid / out_ready        one result request (event or buffer byte)
//  cfg       cfg_we, cfg_index, cfg_wdata register write, no wait
//
// The front end takes a character whenever the four-deep list queue has room.
// The back end sends one result per cycle while the output is not stalled; an item carries
// one to five results, and a character that yields no result is not queued.
// The first result passes through the list queue, the current-list register and the output register.
// Reset is synchronous and clears line state, queue and output valid; no clearing pass.
// A stalled output holds its register while the front end keeps filling the queue.
`include "assert_macros.svh"
module serial_receive_input_qualifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_line,
  input  logic [7:0]  in_char_code,
  input  logic        in_parity_error,
  input  logic        in_framing_error,
  input  logic        in_overrun_error,
  input  logic        in_carrier_detect,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_line,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  sriq_pkg::cfg_t  cfg_r;
  sriq_pkg::plan_t push_plan;
  sriq_pkg::plan_t q_plan;
  logic            push;
  logic            pop;
  logic            q_valid;
  logic            q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_modes <= '0;
      cfg_r.clocal_mask <= '0;
      cfg_r.open_mask <= '0;
      cfg_r.unit_index <= '0;
      cfg_r.total_lines <= sriq_pkg::TOTAL_LINES_RST;
      cfg_r.start_char <= sriq_pkg::START_CHAR_RST;
      cfg_r.stop_char <= sriq_pkg::STOP_CHAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sriq_pkg::CFG_LINE_MODES:  cfg_r.line_modes <= cfg_wdata;
        sriq_pkg::CFG_CLOCAL_MASK: cfg_r.clocal_mask <= cfg_wdata[7:0];
        sriq_pkg::CFG_OPEN_MASK:   cfg_r.open_mask <= cfg_wdata[7:0];
        sriq_pkg::CFG_UNIT_INDEX:  cfg_r.unit_index <= cfg_wdata[2:0];
        sriq_pkg::CFG_TOTAL_LINES: cfg_r.total_lines <= cfg_wdata[6:0];
        sriq_pkg::CFG_START_CHAR:  cfg_r.start_char <= cfg_wdata[6:0];
        sriq_pkg::CFG_STOP_CHAR:   cfg_r.stop_char <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  sriq_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_line           (in_line),
    .in_char_code      (in_char_code),
    .in_parity_error   (in_parity_error),
    .in_framing_error  (in_framing_error),
    .in_overrun_error  (in_overrun_error),
    .in_carrier_detect (in_carrier_detect),
    .q_full            (q_full),
    .push              (push),
    .push_plan         (push_plan)
  );

  sriq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_plan (push_plan),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_plan    (q_plan),
    .q_full    (q_full)
  );

  sriq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_plan        (q_plan),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line      (out_line),
    .out_event_res (out_event_res),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  `ASSERT_CLK(a_ready_when_room, clk, rst_n, in_ready == !q_full, "Input ready does not follow queue room.")

endmodule
